// ----- sv/lzo1x_stream_decompressor_macros.svh -----
// ----------------------------------------------------------------------------
// LZO1X decompressor assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef LZO1X_STREAM_DECOMPRESSOR_MACROS_SVH
`define LZO1X_STREAM_DECOMPRESSOR_MACROS_SVH

// assert that an antecedent implies a consequent in the same cycle
`define LZD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// assert that an antecedent implies a consequent in the next cycle
`define LZD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lzd_pkg.sv -----
// ----------------------------------------------------------------------------
// LZO1X decompressor package
// Widths, phase codes, error codes and field types.
// ----------------------------------------------------------------------------
package lzd_pkg;

    localparam int HISTORY_BYTES = 65536;
    localparam int LENGTH_BITS   = 24;
    localparam int HIST_AW       = $clog2(HISTORY_BYTES);
    localparam int CNT_W         = $clog2(HISTORY_BYTES + 1);

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    typedef logic [1:0] t_err;
    localparam t_err ERR_NONE     = 2'd0;
    localparam t_err ERR_DISTANCE = 2'd1;
    localparam t_err ERR_ITEM     = 2'd2;
    localparam t_err ERR_LENGTH   = 2'd3;

    typedef enum logic [3:0] {
        PH_FIRST       = 4'd0,
        PH_TOP         = 4'd1,
        PH_AFTER_LIT   = 4'd2,
        PH_AFTER_MATCH = 4'd3,
        PH_LIT_EXT     = 4'd4,
        PH_LIT         = 4'd5,
        PH_M_EXT       = 4'd6,
        PH_DIST_LO     = 4'd7,
        PH_DIST_HI     = 4'd8,
        PH_COPY        = 4'd9,
        PH_DONE        = 4'd10
    } t_phase;

    typedef struct packed {
        logic       mode;
        logic [7:0] in_byte;
    } t_in;

    typedef struct packed {
        logic       out_valid;
        logic [7:0] out_byte;
        logic       busy_res;
        logic       stream_done;
        t_err       error_code;
    } t_out;

endpackage

// ----- sv/lzd_stream_if.sv -----
// ----------------------------------------------------------------------------
// LZO1X decompressor channel interfaces
// Valid/ready channels for input and result beats.
// ----------------------------------------------------------------------------
interface lzd_in_if;
    logic         valid;
    logic         ready;
    lzd_pkg::t_in payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface lzd_out_if;
    logic          valid;
    logic          ready;
    lzd_pkg::t_out payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/lzd_history_ram.sv -----
// ----------------------------------------------------------------------------
// LZO1X history memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module lzd_history_ram (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [lzd_pkg::HIST_AW-1:0]  i_waddr,
    input  logic [7:0]                   i_wdata,
    input  logic                         i_re,
    input  logic [lzd_pkg::HIST_AW-1:0]  i_raddr,
    output logic [7:0]                   o_rdata
);
    logic [7:0] r_mem [lzd_pkg::HISTORY_BYTES];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ----- sv/lzo1x_stream_decompressor.sv -----
// ----------------------------------------------------------------------------
// LZO1X stream decompressor
// Decodes one compressed byte or one match advance per beat.
// ----------------------------------------------------------------------------
// A result beat appears in the cycle after its input beat is accepted.
// One beat per cycle when not stalled; history RAM reads for the next copy
// byte are issued ahead; back-to-back copies forward the just-written byte.
// Reset: synchronous active-low; control clears at once, no clearing pass,
// history contents stay undefined until written.
module lzo1x_stream_decompressor (
    input  logic          i_clk,
    input  logic          i_rst_n,
    lzd_in_if.sink        i_in,
    lzd_out_if.source     o_out
);
    localparam int AW = lzd_pkg::HIST_AW;
    localparam int LW = lzd_pkg::LENGTH_BITS;
    localparam int CW = lzd_pkg::CNT_W;
    localparam logic [CW-1:0] CNT_FULL = CW'(lzd_pkg::HISTORY_BYTES);

    lzd_pkg::t_phase r_phase, n_phase;
    logic [7:0]    r_instr, n_instr;
    logic [LW-1:0] r_len, n_len;
    logic [7:0]    r_olo, n_olo;
    logic [1:0]    r_trail, n_trail;
    logic [AW-1:0] r_src, n_src;
    logic [LW-1:0] r_rem, n_rem;
    logic          r_alr, n_alr;
    logic          r_fin, n_fin;
    logic [AW-1:0] r_wp, n_wp;
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_ovalid;
    lzd_pkg::t_out r_out, n_out;
    logic          r_fwd_ok, n_fwd_ok;
    logic [7:0]    r_fwd, n_fwd;

    logic          acc;
    logic [7:0]    ram_q, copy_byte, b;
    logic          we, re;
    logic [AW-1:0] raddr;
    lzd_pkg::t_err err;
    logic [LW:0]   sum;
    logic [LW-1:0] sat;
    logic          sat_ovf;
    logic [31:0]   mdist, word;
    logic [LW-1:0] mlen, mbase;
    logic [8:0]    addend;
    logic          do_fin, eop, out_v;
    logic [7:0]    ob;

    assign i_in.ready = i_rst_n && (!r_ovalid || o_out.ready);
    assign acc = i_in.valid && i_in.ready;
    assign b = i_in.payload.in_byte;
    assign copy_byte = r_fwd_ok ? r_fwd : ram_q;

    lzd_history_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_wp),
        .i_wdata (ob),
        .i_re    (re),
        .i_raddr (raddr),
        .o_rdata (ram_q)
    );

    always_comb begin
        sum = {1'b0, r_len} + {{(LW-8){1'b0}}, addend};
        sat_ovf = sum[LW];
        sat = sat_ovf ? lzd_pkg::LEN_MAX : sum[LW-1:0];
    end

    always_comb begin
        n_phase = r_phase; n_instr = r_instr; n_len = r_len; n_olo = r_olo;
        n_trail = r_trail; n_src = r_src; n_rem = r_rem; n_alr = r_alr;
        n_fin = r_fin; n_wp = r_wp; n_cnt = r_cnt;
        err = lzd_pkg::ERR_NONE; out_v = 1'b0; ob = 8'd0;
        addend = 9'd0; mdist = 32'd0; mlen = '0; mbase = '0; do_fin = 1'b0;
        word = {16'd0, b, r_olo};
        eop = 1'b0;
        if (acc) begin
            if (i_in.payload.mode) begin
                if (r_phase != lzd_pkg::PH_COPY) begin
                    err = lzd_pkg::ERR_ITEM;
                end else begin
                    out_v = 1'b1; ob = copy_byte;
                    n_src = r_src + 1'b1;
                    n_rem = r_rem - 1'b1;
                    if (r_rem == LW'(1)) eop = 1'b1;
                end
            end else begin
                case (r_phase)
                    lzd_pkg::PH_FIRST, lzd_pkg::PH_TOP: begin
                        if (r_phase == lzd_pkg::PH_FIRST && b > 8'd17) begin
                            n_len = LW'(b - 8'd17);
                            n_alr = (b - 8'd17) >= 8'd4;
                            n_phase = lzd_pkg::PH_LIT;
                        end else if (b >= 8'd16) begin
                            n_instr = b; n_len = '0;
                            if (b >= 8'd64) n_phase = lzd_pkg::PH_DIST_LO;
                            else if (b >= 8'd32)
                                n_phase = (b[4:0] == 5'd0) ? lzd_pkg::PH_M_EXT
                                                           : lzd_pkg::PH_DIST_LO;
                            else n_phase = (b[2:0] == 3'd0) ? lzd_pkg::PH_M_EXT
                                                            : lzd_pkg::PH_DIST_LO;
                        end else if (b == 8'd0) begin
                            n_len = '0; n_phase = lzd_pkg::PH_LIT_EXT;
                        end else begin
                            n_len = LW'(b) + LW'(3); n_alr = 1'b1;
                            n_phase = lzd_pkg::PH_LIT;
                        end
                    end
                    lzd_pkg::PH_AFTER_LIT, lzd_pkg::PH_AFTER_MATCH: begin
                        n_instr = b;
                        if (b < 8'd16) n_phase = lzd_pkg::PH_DIST_LO;
                        else begin
                            n_len = '0;
                            if (b >= 8'd64) n_phase = lzd_pkg::PH_DIST_LO;
                            else if (b >= 8'd32)
                                n_phase = (b[4:0] == 5'd0) ? lzd_pkg::PH_M_EXT
                                                           : lzd_pkg::PH_DIST_LO;
                            else n_phase = (b[2:0] == 3'd0) ? lzd_pkg::PH_M_EXT
                                                            : lzd_pkg::PH_DIST_LO;
                        end
                    end
                    lzd_pkg::PH_LIT_EXT, lzd_pkg::PH_M_EXT: begin
                        if (b == 8'd0) addend = 9'd255;
                        else if (r_phase == lzd_pkg::PH_LIT_EXT) addend = 9'd18 + 9'(b);
                        else addend = 9'(b) + ((r_instr >= 8'd32) ? 9'd31 : 9'd7);
                        n_len = sat;
                        if (sat_ovf) err = lzd_pkg::ERR_LENGTH;
                        if (b != 8'd0) begin
                            if (r_phase == lzd_pkg::PH_LIT_EXT) begin
                                n_alr = 1'b1; n_phase = lzd_pkg::PH_LIT;
                            end else n_phase = lzd_pkg::PH_DIST_LO;
                        end
                    end
                    lzd_pkg::PH_LIT: begin
                        out_v = 1'b1; ob = b;
                        n_len = r_len - 1'b1;
                        if (r_len == LW'(1))
                            n_phase = r_alr ? lzd_pkg::PH_AFTER_LIT
                                            : lzd_pkg::PH_AFTER_MATCH;
                    end
                    lzd_pkg::PH_DIST_LO: begin
                        n_olo = b;
                        if (r_instr < 8'd16) begin
                            mdist = 32'd1 + 32'(r_instr[3:2]) + (32'(b) << 2);
                            if (r_alr) begin
                                mdist = mdist + 32'h0800; mlen = LW'(3);
                            end else mlen = LW'(2);
                            do_fin = 1'b1;
                        end else if (r_instr >= 8'd64) begin
                            mdist = 32'd1 + 32'(r_instr[4:2]) + (32'(b) << 3);
                            mlen = LW'(r_instr[7:5]) + LW'(1);
                            do_fin = 1'b1;
                        end else n_phase = lzd_pkg::PH_DIST_HI;
                        n_trail = r_instr[1:0];
                    end
                    lzd_pkg::PH_DIST_HI: begin
                        n_trail = r_olo[1:0];
                        if (r_instr >= 8'd32) begin
                            mbase = (r_instr[4:0] != 5'd0) ? LW'(r_instr[4:0]) : r_len;
                            mdist = 32'd1 + (word >> 2);
                            do_fin = 1'b1;
                        end else begin
                            mdist = (32'(r_instr[3]) << 14) + (word >> 2);
                            if (mdist == 32'd0) begin
                                n_fin = 1'b1; n_phase = lzd_pkg::PH_DONE;
                            end else begin
                                mdist = mdist + 32'h4000;
                                mbase = (r_instr[2:0] != 3'd0) ? LW'(r_instr[2:0]) : r_len;
                                do_fin = 1'b1;
                            end
                        end
                        if (do_fin) begin
                            mlen = (mbase > lzd_pkg::LEN_MAX - LW'(2)) ? lzd_pkg::LEN_MAX
                                                                       : mbase + LW'(2);
                            if (mbase > lzd_pkg::LEN_MAX - LW'(2)) err = lzd_pkg::ERR_LENGTH;
                        end
                    end
                    default: err = lzd_pkg::ERR_ITEM;
                endcase
                if (do_fin) begin
                    if (mdist > 32'(r_cnt)) begin
                        err = lzd_pkg::ERR_DISTANCE;
                        n_rem = '0;
                        eop = 1'b1;
                    end else begin
                        n_src = r_wp - mdist[AW-1:0];
                        n_rem = mlen;
                        n_phase = lzd_pkg::PH_COPY;
                    end
                end
            end
            if (eop) begin
                if (n_trail != 2'd0) begin
                    n_len = LW'(n_trail); n_alr = 1'b0; n_phase = lzd_pkg::PH_LIT;
                end else n_phase = lzd_pkg::PH_TOP;
            end
            if (out_v) begin
                n_wp = r_wp + 1'b1;
                if (r_cnt != CNT_FULL) n_cnt = r_cnt + 1'b1;
            end
        end
        we = out_v;
        re = 1'b1;
        raddr = n_src;
        n_fwd_ok = out_v && (n_src == r_wp);
        n_fwd = ob;
        n_out.out_valid = out_v;
        n_out.out_byte = ob;
        n_out.busy_res = (n_phase == lzd_pkg::PH_COPY);
        n_out.stream_done = n_fin;
        n_out.error_code = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= lzd_pkg::PH_FIRST;
            r_instr <= '0; r_len <= '0; r_olo <= '0; r_trail <= '0;
            r_src <= '0; r_rem <= '0; r_alr <= 1'b0; r_fin <= 1'b0;
            r_wp <= '0; r_cnt <= '0; r_ovalid <= 1'b0; r_fwd_ok <= 1'b0;
        end else begin
            r_phase <= n_phase; r_instr <= n_instr; r_len <= n_len; r_olo <= n_olo;
            r_trail <= n_trail; r_src <= n_src; r_rem <= n_rem; r_alr <= n_alr;
            r_fin <= n_fin; r_wp <= n_wp; r_cnt <= n_cnt;
            r_fwd_ok <= n_fwd_ok;
            if (acc) r_ovalid <= 1'b1;
            else if (o_out.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd <= n_fwd;
        if (acc) r_out <= n_out;
    end

    assign o_out.valid = r_ovalid;
    assign o_out.payload = r_out;
endmodule

// ----- sv/lzd_checker.sv -----
// ----------------------------------------------------------------------------
// LZO1X decompressor port checker
// Watches the top-level ports and flags inconsistent result beats.
// ----------------------------------------------------------------------------
`include "lzo1x_stream_decompressor_macros.svh"

module lzd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          i_in_ready,
    input logic          i_out_valid,
    input logic          i_out_ready,
    input lzd_pkg::t_out i_out_payload
);
    `LZD_ASSERT_IMPL(a_byte_zero, i_clk, i_rst_n,
        i_out_valid && !i_out_payload.out_valid, i_out_payload.out_byte == 8'd0,
        "out_byte set without out_valid")
    `LZD_ASSERT_IMPL(a_err_no_byte, i_clk, i_rst_n,
        i_out_valid && i_out_payload.error_code == lzd_pkg::ERR_ITEM,
        !i_out_payload.out_valid, "byte emitted on an unexpected item")
    `LZD_ASSERT_NEXT(a_beat_follows, i_clk, i_rst_n,
        i_in_valid && i_in_ready, i_out_valid,
        "accepted input produced no result beat")
    `LZD_ASSERT_IMPL(a_ready_free, i_clk, i_rst_n,
        !i_out_valid, i_in_ready, "input stalled with empty output")
    `LZD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n,
        i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload),
        "result beat changed while stalled")
endmodule

bind lzo1x_stream_decompressor lzd_checker u_lzd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_payload (o_out.payload)
);
